FILE: hdl/lgs_pkg.sv
// Shared constants, codes and controller/datapath bundles for the life generation block.
// No dependencies; every other file in hdl/ except lgs_ram.sv refers to it by scoped names.
package lgs_pkg;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Default grid side (MAX_SIDE parameter of the top level)
  localparam int MAX_SIDE_DEF = 64;

  // Reset value of both area registers
  localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

  // Neighbor counts of the rule
  localparam logic [3:0] NBR_SURVIVE = 4'd2;
  localparam logic [3:0] NBR_BIRTH   = 4'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_item;
    logic rd_cell;
    logic wr_cell;
    logic cap_cell;
    logic rd_first;
    logic ld_first;
    logic rd_next;
    logic ld_next;
    logic wr_gen;
    logic load_out;
  } lgs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              oor;
    logic              h_zero;
    logic              last_row;
    logic              out_free;
  } lgs_sts_t;

endpackage

FILE: hdl/lgs_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on lgs_pkg for field widths.
interface lgs_item_if;
  logic                       valid;
  logic                       ready;
  logic [lgs_pkg::KIND_W-1:0] kind;
  logic [lgs_pkg::ROW_W-1:0]  row_index;
  logic [lgs_pkg::COL_W-1:0]  col_index;
  logic                       alive_in;

  modport source (output valid, kind, row_index, col_index, alive_in, input ready);
  modport sink   (input valid, kind, row_index, col_index, alive_in, output ready);
endinterface

interface lgs_result_if;
  logic valid;
  logic ready;
  logic alive_out;
  logic out_of_range;

  modport source (output valid, alive_out, out_of_range, input ready);
  modport sink   (input valid, alive_out, out_of_range, output ready);
endinterface

FILE: hdl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/lgs_ctrl.sv
// Controller state machine: sequences cell access, generation sweep and result delivery.
// Depends on lgs_pkg for kind codes and the command/status bundles.
module lgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lgs_pkg::lgs_sts_t sts,
  output lgs_pkg::lgs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_CELL_RD  = 4'd2;
  localparam logic [3:0] S_CELL_WR  = 4'd3;
  localparam logic [3:0] S_CELL_CAP = 4'd4;
  localparam logic [3:0] S_GEN_RD0  = 4'd5;
  localparam logic [3:0] S_GEN_LD0  = 4'd6;
  localparam logic [3:0] S_GEN_RD   = 4'd7;
  localparam logic [3:0] S_GEN_LD   = 4'd8;
  localparam logic [3:0] S_GEN_WR   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          lgs_pkg::KIND_WRITE, lgs_pkg::KIND_READ: begin
            state_next = sts.oor ? S_DONE : S_CELL_RD;
          end
          lgs_pkg::KIND_ADVANCE: begin
            state_next = sts.h_zero ? S_DONE : S_GEN_RD0;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_CELL_RD: begin
        cmd.rd_cell = 1'b1;
        state_next  = (sts.kind == lgs_pkg::KIND_WRITE) ? S_CELL_WR : S_CELL_CAP;
      end
      S_CELL_WR: begin
        cmd.wr_cell = 1'b1;
        state_next  = S_DONE;
      end
      S_CELL_CAP: begin
        cmd.cap_cell = 1'b1;
        state_next   = S_DONE;
      end
      S_GEN_RD0: begin
        cmd.rd_first = 1'b1;
        state_next   = S_GEN_LD0;
      end
      S_GEN_LD0: begin
        cmd.ld_first = 1'b1;
        state_next   = S_GEN_RD;
      end
      S_GEN_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_GEN_LD;
      end
      S_GEN_LD: begin
        cmd.ld_next = 1'b1;
        state_next  = S_GEN_WR;
      end
      S_GEN_WR: begin
        cmd.wr_gen = 1'b1;
        state_next = sts.last_row ? S_DONE : S_GEN_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted item is decoded in the very next cycle
  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> state == S_DISPATCH)
    else $error("accepted item not dispatched");

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");

  // The sweep ends right after the last active row is written
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN_WR && sts.last_row) |=> state == S_DONE)
    else $error("generation sweep overran the last row");

  // Out-of-range accesses never touch the grid
  a_oor_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH && sts.oor) |=> state == S_DONE)
    else $error("out-of-range access reached the grid");

  // One row write source at a time
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_cell, cmd.wr_gen}))
    else $error("two row writes in one cycle");

endmodule

FILE: hdl/lgs_datapath.sv
// Datapath: area registers, item and result registers, row window and rule logic.
// Depends on lgs_pkg and instantiates lgs_ram for the row store.
module lgs_datapath #(
  parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_data,
  input  logic [lgs_pkg::KIND_W-1:0]    kind,
  input  logic [lgs_pkg::ROW_W-1:0]     row_index,
  input  logic [lgs_pkg::COL_W-1:0]     col_index,
  input  logic                          alive_in,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          alive_out,
  output logic                          out_of_range,
  input  lgs_pkg::lgs_cmd_t             cmd,
  output lgs_pkg::lgs_sts_t             sts
);

  localparam int AW  = $clog2(MAX_SIDE);
  localparam int SCW = $clog2(MAX_SIDE + 1);
  localparam int EW  = (SCW > lgs_pkg::CFG_W) ? SCW : lgs_pkg::CFG_W;
  localparam logic [EW-1:0] SIDE_MAX = EW'(MAX_SIDE);

  logic [lgs_pkg::CFG_W-1:0] grid_width;
  logic [lgs_pkg::CFG_W-1:0] grid_height;
  logic [EW-1:0]             w_ext;
  logic [EW-1:0]             h_ext;
  logic [EW-1:0]             w_eff;
  logic [EW-1:0]             h_eff;

  logic [lgs_pkg::KIND_W-1:0] kind_q;
  logic [lgs_pkg::ROW_W-1:0]  row_q;
  logic [lgs_pkg::COL_W-1:0]  col_q;
  logic                       alive_q;
  logic                       oor_q;
  logic                       res_alive;
  logic                       in_area;
  logic                       is_cell;

  logic [EW-1:0]       row_ext;
  logic [EW-1:0]       col_ext;
  logic [AW-1:0]       row_addr;
  logic [AW-1:0]       col_sel;
  logic [AW-1:0]       rc;
  logic [EW-1:0]       rc_plus;
  logic                has_next;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [MAX_SIDE-1:0] wdata;
  logic [MAX_SIDE-1:0] rdata;
  logic [MAX_SIDE-1:0] row_valid;
  logic                rd_valid_q;
  logic [MAX_SIDE-1:0] row_data;
  logic [MAX_SIDE-1:0] cell_row;

  logic [MAX_SIDE-1:0] prev_row;
  logic [MAX_SIDE-1:0] cur_row;
  logic [MAX_SIDE-1:0] nxt_row;
  logic [MAX_SIDE-1:0] col_mask;
  logic [MAX_SIDE-1:0] gen_row;

  // Area registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lgs_pkg::CFG_SIDE_RESET;
      grid_height <= lgs_pkg::CFG_SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lgs_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        lgs_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the area to the stored grid
  assign w_ext = EW'(grid_width);
  assign h_ext = EW'(grid_height);
  assign w_eff = (w_ext > SIDE_MAX) ? SIDE_MAX : w_ext;
  assign h_eff = (h_ext > SIDE_MAX) ? SIDE_MAX : h_ext;

  assign in_area = (EW'(row_index) < h_eff) && (EW'(col_index) < w_eff);
  assign is_cell = (kind == lgs_pkg::KIND_WRITE) || (kind == lgs_pkg::KIND_READ);

  // Item register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      kind_q  <= kind;
      row_q   <= row_index;
      col_q   <= col_index;
      alive_q <= alive_in;
      oor_q   <= is_cell && !in_area;
    end
  end

  assign row_ext  = EW'(row_q);
  assign col_ext  = EW'(col_q);
  assign row_addr = row_ext[AW-1:0];
  assign col_sel  = col_ext[AW-1:0];

  // Row counter for the generation sweep
  assign rc_plus  = EW'(rc) + EW'(1);
  assign has_next = rc_plus < h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
    end else if (cmd.rd_first) begin
      rc <= '0;
    end else if (cmd.wr_gen) begin
      rc <= rc + AW'(1);
    end
  end

  always_comb begin
    if (cmd.rd_cell) begin
      raddr = row_addr;
    end else if (cmd.rd_first) begin
      raddr = '0;
    end else begin
      raddr = rc_plus[AW-1:0];
    end
  end

  // Row store; a row never written reads as all dead
  lgs_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_q <= row_valid[raddr];
  end

  assign row_data = rdata & {MAX_SIDE{rd_valid_q}};

  always_comb begin
    cell_row          = row_data;
    cell_row[col_sel] = alive_q;
  end

  assign we    = cmd.wr_cell || cmd.wr_gen;
  assign waddr = cmd.wr_cell ? row_addr : rc;
  assign wdata = cmd.wr_cell ? cell_row : gen_row;

  // Three-row window of the old grid
  always_ff @(posedge clk) begin
    if (cmd.ld_first) begin
      prev_row <= '0;
      cur_row  <= row_data;
    end else if (cmd.wr_gen) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
    if (cmd.ld_next) begin
      nxt_row <= has_next ? row_data : '0;
    end
  end

  // Rule for one whole row; columns beyond the area keep their old value
  always_comb begin
    logic [MAX_SIDE+1:0] pp;
    logic [MAX_SIDE+1:0] cp;
    logic [MAX_SIDE+1:0] np;
    logic [3:0]          n;
    for (int c = 0; c < MAX_SIDE; c++) begin
      col_mask[c] = EW'(c) < w_eff;
    end
    pp = {1'b0, prev_row & col_mask, 1'b0};
    cp = {1'b0, cur_row & col_mask, 1'b0};
    np = {1'b0, nxt_row & col_mask, 1'b0};
    for (int c = 0; c < MAX_SIDE; c++) begin
      n = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2]) + 4'(cp[c]) + 4'(cp[c+2])
        + 4'(np[c]) + 4'(np[c+1]) + 4'(np[c+2]);
      gen_row[c] = col_mask[c]
                 ? ((n == lgs_pkg::NBR_BIRTH) || (cp[c+1] && n == lgs_pkg::NBR_SURVIVE))
                 : cur_row[c];
    end
  end

  // Result value and output register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      res_alive <= 1'b0;
    end else if (cmd.cap_cell) begin
      res_alive <= row_data[col_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      alive_out    <= res_alive;
      out_of_range <= oor_q;
    end
  end

  assign sts.kind     = kind_q;
  assign sts.oor      = oor_q;
  assign sts.h_zero   = (h_eff == '0);
  assign sts.last_row = (rc_plus == h_eff);
  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: hdl/life_generation_step.sv
// Top level of the Game of Life generation engine: channels, controller and datapath.
// Depends on lgs_pkg, lgs_if.sv, lgs_ctrl and lgs_datapath.
//
// A MAX_SIDE by MAX_SIDE grid of one-bit cells, all dead after reset, kept as MAX_SIDE
// rows of MAX_SIDE bits in one row RAM. Each item writes a cell, reads a cell, or
// advances the active grid_width by grid_height area by one Conway generation; every
// item returns exactly one result. A write or read goes from acceptance to the next
// acceptance through dispatch, row read, row write or bit capture, result load and idle.
// An out-of-range write or read, a generation over zero rows and the unused kind skip
// the grid and go through dispatch, result load and idle only.
// A generation sweeps the H active rows and holds a three-row window of the old grid;
// each row costs a RAM read, a window load and a RAM write through the single read
// port, with all columns of the row updated at once.
// New rows go back in place, since the window keeps the old rows still needed. Rows
// carry a valid bit cleared at reset, so there is no clearing pass after reset.
// The result sits in an output register, so a new item is taken while it waits.
module life_generation_step #(
  parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_data,
  lgs_item_if.sink                      item,
  lgs_result_if.source                  result
);

  lgs_pkg::lgs_cmd_t cmd;
  lgs_pkg::lgs_sts_t sts;
  logic              item_ready;

  // Ready only in idle; everything else stays in the controller
  assign item.ready = item_ready;

  // Sequence the work of one item at a time
  lgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the grid, the area registers and the result register
  lgs_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (item.kind),
    .row_index    (item.row_index),
    .col_index    (item.col_index),
    .alive_in     (item.alive_in),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .alive_out    (result.alive_out),
    .out_of_range (result.out_of_range),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
